FILE: rtl/core/motor_step_packet_framer_unit_macros.svh
// assertion macros shared by the framer
`ifndef MOTOR_STEP_PACKET_FRAMER_UNIT_MACROS_SVH
`define MOTOR_STEP_PACKET_FRAMER_UNIT_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define MSP_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/core/msp_pkg.sv
package msp_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int MOTOR_W  = 3;
   localparam int LEN_W    = 32;
   localparam int SPM_W    = 24;
   localparam int WORD_W   = 32;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int TARGET_W = 40;
   localparam int POS_W    = 48;
   localparam int CNT_W    = 5;

   localparam int NUM_MOTORS_DEF = 8;

   // operation codes
   localparam logic [OP_W-1:0] OP_START  = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS_PER_MM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCELERATION = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VELOCITY     = 2'd2;

   // register reset values
   localparam logic [SPM_W-1:0]  SPM_RESET   = 24'd137971;
   localparam logic [WORD_W-1:0] ACCEL_RESET = 32'd200;
   localparam logic [WORD_W-1:0] VEL_RESET   = 32'd20000;

   // packet bytes
   localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'd170;
   localparam logic [BYTE_W-1:0] EXIT_BYTE = 8'd180;
   localparam logic [BYTE_W-1:0] MOVE_LEN  = 8'd17;
   localparam logic [BYTE_W-1:0] MOVE_CMD  = 8'd11;
   localparam logic [BYTE_W-1:0] GO_LEN    = 8'd4;
   localparam logic [BYTE_W-1:0] GO_CMD    = 8'd12;
   localparam logic [BYTE_W-1:0] GO_CSUM   = HDR_BYTE ^ GO_LEN ^ GO_CMD;

   // final byte position of a move packet, alone and with the go packet
   localparam logic [CNT_W-1:0] MOVE_LAST = 5'd16;
   localparam logic [CNT_W-1:0] GO_LAST   = 5'd20;

   localparam logic [WORD_W-1:0] STEPS_MAX = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] STEPS_MIN = 32'h8000_0000;

   function automatic logic [BYTE_W-1:0] word_xor(input logic [WORD_W-1:0] w);
      return w[31:24] ^ w[23:16] ^ w[15:8] ^ w[7:0];
   endfunction

endpackage

FILE: rtl/core/msp_channels.sv
// input item channel
interface msp_req_if import msp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [MOTOR_W-1:0] motor_index;
   logic [LEN_W-1:0]   length_mm;

   modport source (output valid, operation, motor_index, length_mm, input ready);
   modport sink   (input valid, operation, motor_index, length_mm, output ready);
endinterface

// result item channel, one byte per item
interface msp_rsp_if import msp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_byte;

   modport source (output valid, out_byte, last_byte, input ready);
   modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// register write channel
interface msp_csr_if import msp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    write_data;

   modport source (output valid, index, write_data, input ready);
   modport sink   (input valid, index, write_data, output ready);
endinterface

FILE: rtl/core/motor_step_packet_framer_unit.sv
// channel   role    payload
// req_if    sink    operation, motor_index, length_mm
// rsp_if    source  out_byte, last_byte
// csr_if    sink    index, write_data (always ready)
//
// an item is taken into stage 1, passes to stage 2 and is then loaded into the byte serializer,
//   which drives its first byte; the scaling multiplier sits between the first two stages
// a move item sends 17 bytes, 21 for the last motor, one per cycle while rsp_if.ready is high; a finish item
//   sends one; the output port sets the sustained rate at one byte per cycle
// start and ignored items never wait on the output in stage 2
// reset clears the per-motor valid bits at once; no clearing pass, no idle time
// rsp_if.ready low holds the serializer, then the two stages behind it fill
`include "motor_step_packet_framer_unit_macros.svh"

module motor_step_packet_framer_unit import msp_pkg::*; #(
   parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   msp_req_if.sink  req_if,
   msp_rsp_if.source rsp_if,
   msp_csr_if.sink  csr_if
);

   localparam int AW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam logic [4:0] MOTOR_LIMIT = 5'(NUM_MOTORS);
   localparam logic [4:0] MOTOR_LAST  = 5'(NUM_MOTORS - 1);

   typedef enum logic [2:0] {
      SER_IDLE = 3'b001,
      SER_MOVE = 3'b010,
      SER_EXIT = 3'b100
   } ser_state_type;

   // configuration registers
   logic [SPM_W-1:0]  spm_ff;
   logic [WORD_W-1:0] accel_ff;
   logic [WORD_W-1:0] vel_ff;

   // position memory, valid bits stand in for the zero reset
   logic [POS_W-1:0]      mem [NUM_MOTORS];
   logic [NUM_MOTORS-1:0] vbits_ff;
   logic [POS_W-1:0]      mem_rd_ff;
   logic                  rd_vld_ff;
   logic                  byp_hit_ff;
   logic [POS_W-1:0]      byp_data_ff;

   // stage 1: accepted item, memory read in flight
   logic               s1_valid_ff;
   logic [OP_W-1:0]    s1_op_ff;
   logic [MOTOR_W-1:0] s1_motor_ff;
   logic [LEN_W-1:0]   s1_len_ff;

   // stage 2: scaled target and current position
   logic                s2_valid_ff;
   logic [OP_W-1:0]     s2_op_ff;
   logic [MOTOR_W-1:0]  s2_motor_ff;
   logic [TARGET_W-1:0] s2_target_ff;
   logic [POS_W-1:0]    s2_pos_ff;

   // byte serializer, doubles as the output register
   ser_state_type      ser_state_ff, ser_state_in;
   logic [CNT_W-1:0]   ser_cnt_ff, ser_cnt_in;
   logic [MOTOR_W-1:0] ser_motor_ff;
   logic [WORD_W-1:0]  ser_steps_ff;
   logic [BYTE_W-1:0]  ser_cs_ff;
   logic               ser_go_ff;

   logic                req_take;
   logic [AW-1:0]       req_addr;
   logic                s1_adv, s2_adv;
   logic [POS_W-1:0]    s1_pos;
   logic [2*WORD_W-1-8:0] s1_prod;
   logic                s2_in_range, s2_writes, s2_silent;
   logic                rsp_take, ser_last, ser_free, ser_load;
   logic signed [POS_W:0] diff;
   logic [WORD_W:0]     whole;
   logic [WORD_W-1:0]   steps;
   logic [POS_W-1:0]    new_pos;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [POS_W-1:0]    wr_data;
   logic [BYTE_W-1:0]   move_cs;
   logic [BYTE_W-1:0]   byte_sel;

   // configuration writes, taken in every cycle
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff   <= SPM_RESET;
         accel_ff <= ACCEL_RESET;
         vel_ff   <= VEL_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_STEPS_PER_MM: spm_ff   <= csr_if.write_data[SPM_W-1:0];
            CSR_ACCELERATION: accel_ff <= csr_if.write_data;
            CSR_VELOCITY:     vel_ff   <= csr_if.write_data;
            default: ;
         endcase
      end
   end

   // handshake and stage advance
   assign req_take = req_if.valid && req_if.ready;
   assign req_addr = AW'({2'b00, req_if.motor_index});
   assign rsp_take = rsp_if.valid && rsp_if.ready;

   // serializer can take a new packet when empty or handing over its last byte
   assign ser_free = (ser_state_ff == SER_IDLE) || (rsp_take && ser_last);

   // start and ignored items leave no bytes, so they pass the serializer by
   assign s2_in_range = ({2'b00, s2_motor_ff} < MOTOR_LIMIT);
   assign s2_writes   = s2_in_range && ((s2_op_ff == OP_START) || (s2_op_ff == OP_MOVE));
   assign s2_silent   = !((s2_op_ff == OP_FINISH) || (s2_in_range && s2_op_ff == OP_MOVE));
   assign s2_adv      = s2_valid_ff && (s2_silent || ser_free);
   assign s1_adv      = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign ser_load    = s2_adv && !s2_silent;

   // memory: one write port from commit, one read port at accept
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_take) begin
         mem_rd_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vbits_ff <= '0;
      end else if (wr_en) begin
         vbits_ff[wr_addr] <= 1'b1;
      end
   end

   // read-during-write to the same motor takes the value being written
   always_ff @(posedge clock) begin
      if (req_take) begin
         rd_vld_ff   <= vbits_ff[req_addr];
         byp_hit_ff  <= wr_en && (s2_motor_ff == req_if.motor_index);
         byp_data_ff <= wr_data;
      end
   end

   // stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_if.operation;
         s1_motor_ff <= req_if.motor_index;
         s1_len_ff   <= req_if.length_mm;
      end
   end

   assign s1_pos  = byp_hit_ff ? byp_data_ff : (rd_vld_ff ? mem_rd_ff : '0);
   // length Q16.16 times factor Q8.16, 56-bit product
   assign s1_prod = (2*WORD_W-8)'(s1_len_ff) * (2*WORD_W-8)'(spm_ff);

   // stage 2; a commit to the same motor in the same cycle is forwarded
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_valid_ff || s2_adv) begin
         s2_valid_ff <= s1_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_op_ff     <= s1_op_ff;
         s2_motor_ff  <= s1_motor_ff;
         s2_target_ff <= s1_prod[2*WORD_W-9:16];
         s2_pos_ff    <= (wr_en && (s2_motor_ff == s1_motor_ff)) ? wr_data : s1_pos;
      end
   end

   // floored step difference: arithmetic shift drops the fraction toward minus
   assign diff  = $signed({9'b0, s2_target_ff}) - $signed({s2_pos_ff[POS_W-1], s2_pos_ff});
   assign whole = diff[POS_W:16];

   // clamp to a signed 32-bit count
   always_comb begin
      if (whole[WORD_W] != whole[WORD_W-1]) begin
         steps = whole[WORD_W] ? STEPS_MIN : STEPS_MAX;
      end else begin
         steps = whole[WORD_W-1:0];
      end
   end

   // position advances by the whole count, kept modulo 2^48
   assign new_pos = s2_pos_ff + {steps, 16'h0000};

   assign wr_en   = s2_adv && s2_writes;
   assign wr_addr = AW'({2'b00, s2_motor_ff});
   assign wr_data = (s2_op_ff == OP_START) ? {8'h00, s2_target_ff} : new_pos;

   assign move_cs = HDR_BYTE ^ MOVE_LEN ^ MOVE_CMD ^ {5'b00000, s2_motor_ff}
                  ^ word_xor(accel_ff) ^ word_xor(vel_ff) ^ word_xor(steps);

   // serializer control
   always_comb begin
      unique case (ser_state_ff)
         SER_EXIT: ser_last = 1'b1;
         SER_MOVE: ser_last = (ser_cnt_ff == (ser_go_ff ? GO_LAST : MOVE_LAST));
         default:  ser_last = 1'b0;
      endcase
   end

   always_comb begin
      ser_state_in = ser_state_ff;
      ser_cnt_in   = ser_cnt_ff;
      if (ser_load) begin
         ser_state_in = (s2_op_ff == OP_FINISH) ? SER_EXIT : SER_MOVE;
         ser_cnt_in   = '0;
      end else if (rsp_take) begin
         if (ser_last) begin
            ser_state_in = SER_IDLE;
         end else begin
            ser_cnt_in = ser_cnt_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_state_ff <= SER_IDLE;
         ser_cnt_ff   <= '0;
      end else begin
         ser_state_ff <= ser_state_in;
         ser_cnt_ff   <= ser_cnt_in;
      end
   end

   // packet fields captured at commit
   always_ff @(posedge clock) begin
      if (ser_load) begin
         ser_motor_ff <= s2_motor_ff;
         ser_steps_ff <= steps;
         ser_cs_ff    <= move_cs;
         ser_go_ff    <= ({2'b00, s2_motor_ff} == MOTOR_LAST);
      end
   end

   // byte select: header, length, command, motor, three big-endian words, checksum, go packet
   always_comb begin
      unique case (ser_cnt_ff)
         5'd0:  byte_sel = HDR_BYTE;
         5'd1:  byte_sel = MOVE_LEN;
         5'd2:  byte_sel = MOVE_CMD;
         5'd3:  byte_sel = {5'b00000, ser_motor_ff};
         5'd4:  byte_sel = accel_ff[31:24];
         5'd5:  byte_sel = accel_ff[23:16];
         5'd6:  byte_sel = accel_ff[15:8];
         5'd7:  byte_sel = accel_ff[7:0];
         5'd8:  byte_sel = vel_ff[31:24];
         5'd9:  byte_sel = vel_ff[23:16];
         5'd10: byte_sel = vel_ff[15:8];
         5'd11: byte_sel = vel_ff[7:0];
         5'd12: byte_sel = ser_steps_ff[31:24];
         5'd13: byte_sel = ser_steps_ff[23:16];
         5'd14: byte_sel = ser_steps_ff[15:8];
         5'd15: byte_sel = ser_steps_ff[7:0];
         5'd16: byte_sel = ser_cs_ff;
         5'd17: byte_sel = HDR_BYTE;
         5'd18: byte_sel = GO_LEN;
         5'd19: byte_sel = GO_CMD;
         5'd20: byte_sel = GO_CSUM;
         default: byte_sel = '0;
      endcase
   end

   assign rsp_if.valid     = (ser_state_ff != SER_IDLE);
   assign rsp_if.out_byte  = (ser_state_ff == SER_EXIT) ? EXIT_BYTE : byte_sel;
   assign rsp_if.last_byte = ser_last;

   // a held stage 1 means no commit, which the read bypass relies on
   `MSP_ASSERT_SAME(a_s1_hold_no_commit, s1_valid_ff && !s1_adv, s2_valid_ff && !s2_adv && !wr_en, "stage 1 held while a commit happened")
   // only motors that exist are ever written
   `MSP_ASSERT_SAME(a_write_in_range, wr_en, {2'b00, s2_motor_ff} < MOTOR_LIMIT, "position write for a missing motor")
   // move byte counter never runs past the packet end
   `MSP_ASSERT_SAME(a_cnt_bound, ser_state_ff == SER_MOVE, ser_cnt_ff <= (ser_go_ff ? GO_LAST : MOVE_LAST), "byte counter past packet end")
   // after the last byte with nothing loaded, the output goes empty
   `MSP_ASSERT_NEXT(a_drain_empty, rsp_take && ser_last && !ser_load, !rsp_if.valid, "output still valid after final byte")

endmodule
